>>> hdl/icsp_pkg.sv
// Shared types and constants for the serial programming command shifter.
package icsp_pkg;

  // Frame geometry of the programming link
  localparam int CMD_BITS   = 6;
  localparam int FRAME_BITS = 16;
  localparam int SHIFT_BITS = CMD_BITS + FRAME_BITS;
  localparam int CNT_BITS   = $clog2(SHIFT_BITS + 1);
  localparam int DATA_BITS  = FRAME_BITS - 2;
  localparam int READ_BITS  = FRAME_BITS - 1;

  // Request kinds
  localparam logic [1:0] KIND_CMD   = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;
  localparam logic [1:0] KIND_TICK  = 2'd3;

  // Incoming request
  typedef struct packed {
    logic [1:0]           kind;
    logic [CMD_BITS-1:0]  command;
    logic [DATA_BITS-1:0] write_data;
    logic                 data_in;
  } req_t;

  // One bit pulse on the link
  typedef struct packed {
    logic                 data_out;
    logic                 data_drive;
    logic                 last;
    logic [READ_BITS-1:0] read_value;
  } rsp_t;

  // Core outputs toward the result register
  typedef struct packed {
    logic produced;
    logic busy;
  } core_stat_t;

endpackage

>>> hdl/icsp_core.sv
// Transaction state and one-pulse step logic of the command shifter.
module icsp_core import icsp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  req_t       req,
  output rsp_t       result,
  output core_stat_t stat
);

  logic                  busy;
  logic [1:0]            ttype;
  logic [CNT_BITS-1:0]   bit_count;
  logic [SHIFT_BITS-1:0] out_shift;
  logic [FRAME_BITS-1:0] in_shift;

  logic                  busy_next;
  logic [1:0]            ttype_next;
  logic [CNT_BITS-1:0]   bit_count_next;
  logic [SHIFT_BITS-1:0] out_shift_next;
  logic [FRAME_BITS-1:0] in_shift_next;

  logic                  is_tick;
  logic                  read_phase;
  logic [CNT_BITS-1:0]   cnt_inc;
  logic [CNT_BITS-1:0]   total;
  logic                  is_last;
  logic [FRAME_BITS-1:0] in_upd;
  logic [FRAME_BITS-1:0] frame;

  // Per-pulse decode
  always_comb begin
    is_tick    = (req.kind == KIND_TICK);
    total      = (ttype == KIND_CMD) ? CNT_BITS'(CMD_BITS) : CNT_BITS'(SHIFT_BITS);
    read_phase = (ttype == KIND_READ) && (bit_count >= CNT_BITS'(CMD_BITS));
    cnt_inc    = bit_count + 1'b1;
    is_last    = (cnt_inc >= total);
    in_upd     = read_phase ? {req.data_in, in_shift[FRAME_BITS-1:1]} : in_shift;
    frame      = (req.kind == KIND_WRITE) ? {1'b0, req.write_data, 1'b0} : '0;
  end

  // Next state and result
  always_comb begin
    busy_next      = busy;
    ttype_next     = ttype;
    bit_count_next = bit_count;
    out_shift_next = out_shift;
    in_shift_next  = in_shift;
    stat.produced  = 1'b0;
    stat.busy      = busy;
    result.data_out   = read_phase ? 1'b0 : out_shift[0];
    result.data_drive = !read_phase;
    result.last       = is_last;
    result.read_value = (is_last && ttype == KIND_READ) ? in_upd[FRAME_BITS-1:1] : '0;
    if (fire) begin
      if (!is_tick) begin
        // start request, dropped while a transaction runs
        if (!busy) begin
          busy_next      = 1'b1;
          ttype_next     = req.kind;
          bit_count_next = '0;
          in_shift_next  = '0;
          out_shift_next = {frame, req.command};
        end
      end else if (busy) begin
        stat.produced  = 1'b1;
        in_shift_next  = in_upd;
        out_shift_next = out_shift >> 1;
        bit_count_next = is_last ? '0 : cnt_inc;
        busy_next      = !is_last;
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      ttype     <= KIND_CMD;
      bit_count <= '0;
      out_shift <= '0;
      in_shift  <= '0;
    end else begin
      busy      <= busy_next;
      ttype     <= ttype_next;
      bit_count <= bit_count_next;
      out_shift <= out_shift_next;
      in_shift  <= in_shift_next;
    end
  end

endmodule

>>> hdl/icsp_command_shifter_unit.sv
// Top level: request register, shifter core and result register.
// A tick request's pulse passes through the request register and then the result register.
// Throughput: one request per cycle while rsp_stall does not hold the result register.
// Start requests and ticks while idle give no pulse.
// Synchronous active-high reset clears the valid flags of both registers and all shifter state.
module icsp_command_shifter_unit import icsp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  logic       req_full;
  req_t       req_q;
  logic       advance;
  logic       fire;
  rsp_t       result;
  core_stat_t stat;

  // Pipeline moves when the result register is free or being drained
  assign advance   = !rsp_valid || !rsp_stall;
  assign req_stall = req_full && !advance;
  assign fire      = req_full && advance;

  // Request register
  always_ff @(posedge clk) begin
    if (rst) begin
      req_full <= 1'b0;
    end else if (req_valid && !req_stall) begin
      req_full <= 1'b1;
    end else if (advance) begin
      req_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      req_q <= req;
    end
  end

  icsp_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .req    (req_q),
    .result (result),
    .stat   (stat)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= fire && stat.produced;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && stat.produced) begin
      rsp <= result;
    end
  end

`ifndef SYNTHESIS
  // Received word only shows on the final pulse
  a_rv_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.last |-> rsp.read_value == '0)
    else $error("read_value set outside final pulse");

  // Target-driven pulses carry no master level
  a_drive: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.data_drive |-> !rsp.data_out)
    else $error("data_out high while line released");

  // A transaction ends only together with its final pulse
  a_end: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $fell(stat.busy) |-> rsp_valid && rsp.last)
    else $error("transaction ended without final pulse");
`endif

endmodule

>>> tb/sv/tb_icsp_command_shifter_unit.sv
// Self-checking testbench for the serial programming command shifter.
`timescale 1ns / 100ps

module tb_icsp_command_shifter_unit;
  import icsp_pkg::*;

  localparam int RANDOM_REQS    = 400;
  localparam int IDLE_PCT       = 22;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LATENCY        = 2;

  // Data-line patterns for the read frame
  localparam int DIN_RANDOM = 0;
  localparam int DIN_ONES   = 1;
  localparam int DIN_ZEROS  = 2;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  icsp_command_shifter_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow of the shifter state
  logic                  sh_busy  = 1'b0;
  logic [1:0]            sh_kind  = '0;
  logic [CNT_BITS-1:0]   sh_count = '0;
  logic [SHIFT_BITS-1:0] sh_out   = '0;
  logic [FRAME_BITS-1:0] sh_in    = '0;

  rsp_t pulse_q[$];
  int   mismatches  = 0;
  int   useful_reqs = 0;
  bit   idling_on   = 1'b1;
  bit   holdoff_req = 1'b0;
  int   holdoff_left = 0;
  int   quiet_cycles = 0;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Advance the shadow shifter by one request; queue the pulse it makes
  function automatic void predict_pulse(input req_t r);
    rsp_t        p;
    int unsigned total;
    if (r.kind != KIND_TICK) begin
      // start while busy is dropped
      if (!sh_busy) begin
        sh_busy  = 1'b1;
        sh_kind  = r.kind;
        sh_count = '0;
        sh_in    = '0;
        sh_out   = {{FRAME_BITS{1'b0}}, r.command};
        if (r.kind == KIND_WRITE) begin
          sh_out[CMD_BITS +: FRAME_BITS] = {1'b0, r.write_data, 1'b0};
        end
        useful_reqs++;
      end
      return;
    end
    if (!sh_busy) return;
    useful_reqs++;
    p = '0;
    p.data_drive = 1'b1;
    total = (sh_kind == KIND_CMD) ? CMD_BITS : SHIFT_BITS;
    if (sh_kind == KIND_READ && sh_count >= CMD_BITS) begin
      // target owns the line; sample LSB-first
      p.data_drive = 1'b0;
      sh_in = {r.data_in, sh_in[FRAME_BITS-1:1]};
    end else begin
      p.data_out = sh_out[0];
    end
    sh_out   = sh_out >> 1;
    sh_count = sh_count + 1'b1;
    if (sh_count >= total) begin
      p.last   = 1'b1;
      sh_busy  = 1'b0;
      sh_count = '0;
      if (sh_kind == KIND_READ) p.read_value = sh_in[FRAME_BITS-1:1];
    end
    pulse_q.push_back(p);
  endfunction

  task automatic check_pulse(input rsp_t got);
    rsp_t want;
    if (pulse_q.size() == 0) begin
      report_mismatch($sformatf("pulse with none pending: %p", got));
      return;
    end
    want = pulse_q.pop_front();
    if (got.data_out !== want.data_out)
      report_mismatch($sformatf("data_out %b, want %b", got.data_out, want.data_out));
    if (got.data_drive !== want.data_drive)
      report_mismatch($sformatf("data_drive %b, want %b", got.data_drive, want.data_drive));
    if (got.last !== want.last)
      report_mismatch($sformatf("last %b, want %b", got.last, want.last));
    if (got.read_value !== want.read_value)
      report_mismatch($sformatf("read_value %h, want %h", got.read_value, want.read_value));
  endtask

  // Monitor both channels
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall) predict_pulse(req);
      if (rsp_valid && !rsp_stall) check_pulse(rsp);
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (holdoff_req) begin
      holdoff_left = HOLDOFF_CYCLES;
      holdoff_req  = 1'b0;
    end
    if (holdoff_left > 0) begin
      rsp_stall <= 1'b1;
      holdoff_left--;
    end else begin
      rsp_stall <= idling_on && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic req_t make_req(input logic [1:0] kind, input logic [CMD_BITS-1:0] cmd,
                                    input logic [DATA_BITS-1:0] wd, input logic din);
    req_t r;
    r.kind       = kind;
    r.command    = cmd;
    r.write_data = wd;
    r.data_in    = din;
    return r;
  endfunction

  // Offer one request, with random gaps, and wait until it is taken
  task automatic send_request(input req_t r);
    while (idling_on && $urandom_range(99) < IDLE_PCT) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  // Sender goes quiet until every pulse is back
  task automatic wait_for_drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pulse_q.size() != 0) @(posedge clk);
  endtask

  // Start request followed by its full run of ticks; optional stray start mid-run
  task automatic run_transaction(input logic [1:0] kind, input logic [CMD_BITS-1:0] cmd,
                                 input logic [DATA_BITS-1:0] wd, input int din_mode,
                                 input int stray_at);
    int   n_ticks;
    logic din;
    n_ticks = (kind == KIND_CMD) ? CMD_BITS : SHIFT_BITS;
    send_request(make_req(kind, cmd, wd, 1'($urandom)));
    for (int i = 0; i < n_ticks; i++) begin
      if (i == stray_at) begin
        send_request(make_req(2'($urandom_range(2)), CMD_BITS'($urandom),
                              DATA_BITS'($urandom), 1'($urandom)));
      end
      if (din_mode == DIN_ONES) din = 1'b1;
      else if (din_mode == DIN_ZEROS) din = 1'b0;
      else din = 1'($urandom);
      send_request(make_req(KIND_TICK, CMD_BITS'($urandom), DATA_BITS'($urandom), din));
    end
  endtask

  task automatic test_idle_tick();
    send_request(make_req(KIND_TICK, '1, '1, 1'b1));
    send_request(make_req(KIND_TICK, '0, '0, 1'b0));
  endtask

  task automatic test_command_only();
    run_transaction(KIND_CMD, '1, '0, DIN_RANDOM, -1);
  endtask

  task automatic test_write_frame();
    run_transaction(KIND_WRITE, '0, '1, DIN_ONES, 9);
  endtask

  task automatic test_read_frame();
    run_transaction(KIND_READ, '1, '0, DIN_ONES, -1);
  endtask

  // Receiver holds off while requests keep coming, so the input backs up
  task automatic test_receiver_holdoff();
    holdoff_req = 1'b1;
    run_transaction(KIND_READ, CMD_BITS'($urandom), DATA_BITS'($urandom), DIN_RANDOM, -1);
    run_transaction(KIND_WRITE, CMD_BITS'($urandom), DATA_BITS'($urandom), DIN_RANDOM, -1);
  endtask

  task automatic test_drain_pause();
    run_transaction(KIND_CMD, CMD_BITS'($urandom), '0, DIN_RANDOM, -1);
    wait_for_drain();
    run_transaction(KIND_READ, '0, '1, DIN_ZEROS, -1);
  endtask

  // Mostly well-formed transactions with random content, some noise
  task automatic test_random_traffic();
    int                   n;
    int                   pick;
    int                   stray;
    logic [1:0]           kind;
    logic [CMD_BITS-1:0]  cmd;
    logic [DATA_BITS-1:0] wd;
    n = 0;
    while (useful_reqs < RANDOM_REQS) begin
      // a stretch with no idling on either side
      idling_on = !(n >= 8 && n < 16);
      pick = $urandom_range(99);
      if (pick < 8) begin
        send_request(make_req(KIND_TICK, CMD_BITS'($urandom), DATA_BITS'($urandom),
                              1'($urandom)));
      end else begin
        kind = 2'($urandom_range(2));
        case ($urandom_range(9))
          0: cmd = '0;
          1: cmd = '1;
          default: cmd = CMD_BITS'($urandom);
        endcase
        case ($urandom_range(9))
          0: wd = '0;
          1: wd = '1;
          default: wd = DATA_BITS'($urandom);
        endcase
        stray = -1;
        if ($urandom_range(99) < 12) begin
          stray = $urandom_range((kind == KIND_CMD) ? CMD_BITS - 1 : SHIFT_BITS - 1);
        end
        run_transaction(kind, cmd, wd, $urandom_range(DIN_ZEROS), stray);
      end
      n++;
    end
    idling_on = 1'b1;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_idle_tick();
    test_command_only();
    test_write_frame();
    test_read_frame();
    test_receiver_holdoff();
    test_drain_pause();
    test_random_traffic();
    wait_for_drain();
    repeat (LATENCY + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
